// ----- rtl/core/rpc_pkg.sv -----
// shared types and constants for the rectangular/polar cordic converter
// no dependencies
`default_nettype none

package rpc_pkg;

   localparam int DW         = 52;  // cordic vector width, q(f+16)
   localparam int ZW         = 34;  // cordic angle width, q4.30 radians
   localparam int GUARD      = 16;
   localparam int ANG_Q      = 30;
   localparam int MAX_STAGES = 30;

   localparam logic OP_RECT  = 1'b0;
   localparam logic OP_POLAR = 1'b1;

   localparam logic signed [30:0]   INV_GAIN = 31'sd652032874;
   localparam logic signed [ZW-1:0] PI_Q30   = 34'sd3373259426;
   localparam logic signed [27:0]   DEG2RAD  = 28'sd74961321;

   localparam logic signed [ZW-1:0] ATAN_Q30 [MAX_STAGES] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
      34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
      34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
      34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
      34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
      34'sd1023,      34'sd511,       34'sd255,       34'sd127,
      34'sd63,        34'sd31,        34'sd15,        34'sd7,
      34'sd3,         34'sd1
   };

   typedef struct packed {
      logic               polar;
      logic               zero;
      logic               flip;
      logic signed [31:0] echo_a;
      logic signed [31:0] echo_b;
   } side_type;

   typedef struct packed {
      logic signed [DW-1:0] vx;
      logic signed [DW-1:0] vy;
      logic signed [ZW-1:0] z;
      side_type             side;
   } vec_type;

endpackage

`default_nettype wire

// ----- rtl/core/rect_polar_converter.sv -----
// rectangular/polar converter: one req transaction gives one rsp transaction.
// req_op = 0: req_first_value/req_second_value are x and y (signed q.FRAC_BITS);
//   rsp returns x, y, magnitude and atan2 angle in radians (zero for a zero
//   vector). req_op = 1: they are magnitude and angle in degrees; rsp returns
//   x = mag*cos, y = mag*sin, the magnitude and the angle in radians.
// A transaction moves on a rising edge with valid high and stall low.
// The pipeline has six setup stages (degree reduction and the deg-to-rad
//   product), one cell per cordic iteration and three output stages with the
//   last one as result register.
// Throughput is one transaction per cycle while req_stall is low. Every stage
//   keeps its own valid bit, so empty stages fill while rsp_stall holds the
//   result register; req_stall rises only once the whole pipeline is occupied.
// Reset clears all valid bits; nothing is in flight after it.
// depends on rpc_pkg, rpc_prep, rpc_cell, rpc_post
`default_nettype none

module rect_polar_converter #(
   parameter int CORDIC_STAGES = 16,
   parameter int FRAC_BITS     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic signed [31:0] req_first_value,
   input  logic signed [31:0] req_second_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_x_coord,
   output logic signed [31:0] rsp_y_coord,
   output logic signed [31:0] rsp_magnitude,
   output logic signed [31:0] rsp_angle_rad,
   output logic               rsp_mode_polar
);
   import rpc_pkg::*;

   logic    chain_valid [CORDIC_STAGES+1];
   logic    chain_stall [CORDIC_STAGES+1];
   vec_type chain_data  [CORDIC_STAGES+1];

   rpc_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_stall        (req_stall),
      .in_op           (req_op),
      .in_first_value  (req_first_value),
      .in_second_value (req_second_value),
      .out_valid       (chain_valid[0]),
      .out_stall       (chain_stall[0]),
      .out_data        (chain_data[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      rpc_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_stall  (chain_stall[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_stall (chain_stall[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   rpc_post #(
      .FRAC_BITS (FRAC_BITS)
   ) u_post (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (chain_valid[CORDIC_STAGES]),
      .in_stall       (chain_stall[CORDIC_STAGES]),
      .in_data        (chain_data[CORDIC_STAGES]),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_x_coord    (rsp_x_coord),
      .out_y_coord    (rsp_y_coord),
      .out_magnitude  (rsp_magnitude),
      .out_angle_rad  (rsp_angle_rad),
      .out_mode_polar (rsp_mode_polar)
   );

`ifndef SYNTH
   a_rect_mag_nonneg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_mode_polar == OP_RECT)) |-> !rsp_magnitude[31])
      else $error("rectangular transaction with negative magnitude");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_mode_polar == OP_RECT) && (rsp_x_coord == '0)
         && (rsp_y_coord == '0)) |-> ((rsp_magnitude == '0) && (rsp_angle_rad == '0)))
      else $error("zero vector gave nonzero magnitude or angle");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rpc_prep.sv -----
// input conditioning pipeline: vector setup, degree reduction, deg to rad
// depends on rpc_pkg
`default_nettype none

module rpc_prep #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic                in_op,
   input  logic signed [31:0]  in_first_value,
   input  logic signed [31:0]  in_second_value,
   output logic                out_valid,
   input  logic                out_stall,
   output rpc_pkg::vec_type    out_data
);
   import rpc_pkg::*;

   localparam int UW  = 34 - FRAC_BITS;
   localparam int QW  = UW - 8;
   localparam int RW  = FRAC_BITS + 10;
   localparam int PZW = RW + 28;
   localparam int RECIP_SHIFT = 40;
   localparam logic [UW-1:0] OFF =
      UW'(360 * (((1 << (31 - FRAC_BITS)) + 359) / 360));
   localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'd360);
   localparam logic signed [59:0] ANG_HALF = 60'sd2147483648;
   localparam logic signed [PZW-1:0] Z_HALF = PZW'(1) <<< (FRAC_BITS + 1);

   logic [5:0] vld_ff;
   logic [5:0] stall;

   vec_type                 s1_data_ff, s1_data_in;
   logic [UW-1:0]           s1_u_ff, s1_u_in;
   logic [FRAC_BITS-1:0]    s1_lo_ff, s1_lo_in;
   logic signed [62:0]      s1_pmag_ff, s1_pmag_in;
   logic signed [59:0]      s1_pang_ff, s1_pang_in;

   vec_type                 s2_data_ff, s2_data_in;
   logic [UW-1:0]           s2_u_ff;
   logic [QW-1:0]           s2_q0_ff, s2_q0_in;
   logic [FRAC_BITS-1:0]    s2_lo_ff;

   vec_type                 s3_data_ff;
   logic [9:0]              s3_rem_ff, s3_rem_in;
   logic [FRAC_BITS-1:0]    s3_lo_ff;

   vec_type                 s4_data_ff, s4_data_in;
   logic signed [RW-1:0]    s4_r_ff, s4_r_in;

   vec_type                 s5_data_ff;
   logic signed [PZW-1:0]   s5_pz_ff, s5_pz_in;

   vec_type                 s6_data_ff, s6_data_in;

   logic signed [DW-1:0]    a_ext;
   logic signed [DW-1:0]    b_ext;
   logic signed [31:0]      deg_hi;
   logic [UW+31:0]          recip_prod;
   logic [UW-1:0]           q0w;
   logic [UW-1:0]           prod360;
   logic [9:0]              rem;
   logic signed [9:0]       deg_i;
   logic signed [9:0]       deg_f;
   logic                    turn;

   // per-stage stall chain
   always_comb begin
      stall[5] = vld_ff[5] && out_stall;
      stall[4] = vld_ff[4] && stall[5];
      stall[3] = vld_ff[3] && stall[4];
      stall[2] = vld_ff[2] && stall[3];
      stall[1] = vld_ff[1] && stall[2];
      stall[0] = vld_ff[0] && stall[1];
   end

   assign in_stall  = stall[0];
   assign out_valid = vld_ff[5];
   assign out_data  = s6_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (!stall[0]) vld_ff[0] <= in_valid;
         if (!stall[1]) vld_ff[1] <= vld_ff[0];
         if (!stall[2]) vld_ff[2] <= vld_ff[1];
         if (!stall[3]) vld_ff[3] <= vld_ff[2];
         if (!stall[4]) vld_ff[4] <= vld_ff[3];
         if (!stall[5]) vld_ff[5] <= vld_ff[4];
      end
   end

   // stage 1: rectangular setup, degree split, constant products
   always_comb begin
      a_ext = DW'(in_first_value) <<< GUARD;
      b_ext = DW'(in_second_value) <<< GUARD;
      s1_data_in.side.polar  = (in_op == OP_POLAR);
      s1_data_in.side.zero   = (in_first_value == '0) && (in_second_value == '0);
      s1_data_in.side.flip   = 1'b0;
      s1_data_in.side.echo_a = in_first_value;
      s1_data_in.side.echo_b = in_second_value;
      if (in_first_value[31]) begin
         s1_data_in.vx = -a_ext;
         s1_data_in.vy = -b_ext;
         s1_data_in.z  = in_second_value[31] ? -PI_Q30 : PI_Q30;
      end else begin
         s1_data_in.vx = a_ext;
         s1_data_in.vy = b_ext;
         s1_data_in.z  = '0;
      end
      deg_hi     = in_second_value >>> FRAC_BITS;
      s1_u_in    = UW'(deg_hi) + OFF;
      s1_lo_in   = in_second_value[FRAC_BITS-1:0];
      s1_pmag_in = in_first_value * INV_GAIN;
      s1_pang_in = in_second_value * DEG2RAD;
   end

   // stage 2: polar start vector, radian echo, quotient by 360
   always_comb begin
      s2_data_in = s1_data_ff;
      if (s1_data_ff.side.polar) begin
         s2_data_in.vx          = DW'(s1_pmag_ff >>> (ANG_Q - GUARD));
         s2_data_in.vy          = '0;
         s2_data_in.side.echo_b = 32'((s1_pang_ff + ANG_HALF) >>> 32);
      end
      recip_prod = s1_u_ff * RECIP;
      s2_q0_in   = recip_prod[RECIP_SHIFT +: QW];
   end

   // stage 3: remainder by 360, one short
   always_comb begin
      q0w       = UW'(s2_q0_ff);
      prod360   = (q0w << 8) + (q0w << 6) + (q0w << 5) + (q0w << 3);
      s3_rem_in = 10'(s2_u_ff - prod360);
   end

   // stage 4: fold into [-90, 90] degrees
   always_comb begin
      rem   = (s3_rem_ff >= 10'd360) ? (s3_rem_ff - 10'd360) : s3_rem_ff;
      deg_i = (rem >= 10'd180) ? ($signed(rem) - 10'sd360) : $signed(rem);
      turn  = 1'b0;
      deg_f = deg_i;
      if ((deg_i > 10'sd90) || ((deg_i == 10'sd90) && (s3_lo_ff != '0))) begin
         deg_f = deg_i - 10'sd180;
         turn  = 1'b1;
      end else if (deg_i < -10'sd90) begin
         deg_f = deg_i + 10'sd180;
         turn  = 1'b1;
      end
      s4_r_in              = $signed({deg_f, s3_lo_ff});
      s4_data_in           = s3_data_ff;
      s4_data_in.side.flip = s3_data_ff.side.polar && turn;
   end

   // stage 5: degrees to radians
   assign s5_pz_in = s4_r_ff * DEG2RAD;

   // stage 6: round to q30 start angle
   always_comb begin
      s6_data_in = s5_data_ff;
      if (s5_data_ff.side.polar) begin
         s6_data_in.z = ZW'((s5_pz_ff + Z_HALF) >>> (FRAC_BITS + 2));
      end
   end

   always_ff @(posedge clock) begin
      if (!stall[0]) begin
         s1_data_ff <= s1_data_in;
         s1_u_ff    <= s1_u_in;
         s1_lo_ff   <= s1_lo_in;
         s1_pmag_ff <= s1_pmag_in;
         s1_pang_ff <= s1_pang_in;
      end
      if (!stall[1]) begin
         s2_data_ff <= s2_data_in;
         s2_u_ff    <= s1_u_ff;
         s2_q0_ff   <= s2_q0_in;
         s2_lo_ff   <= s1_lo_ff;
      end
      if (!stall[2]) begin
         s3_data_ff <= s2_data_ff;
         s3_rem_ff  <= s3_rem_in;
         s3_lo_ff   <= s2_lo_ff;
      end
      if (!stall[3]) begin
         s4_data_ff <= s4_data_in;
         s4_r_ff    <= s4_r_in;
      end
      if (!stall[4]) begin
         s5_data_ff <= s4_data_ff;
         s5_pz_ff   <= s5_pz_in;
      end
      if (!stall[5]) begin
         s6_data_ff <= s6_data_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rpc_cell.sv -----
// one cordic micro-rotation cell, vectoring or rotation per transaction
// depends on rpc_pkg
`default_nettype none

module rpc_cell #(
   parameter int STAGE = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  rpc_pkg::vec_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output rpc_pkg::vec_type out_data
);
   import rpc_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = ATAN_Q30[STAGE];

   logic                 vld_ff;
   vec_type              data_ff, data_in;
   logic signed [DW-1:0] vx;
   logic signed [DW-1:0] vy;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic                 rot_pos;

   assign in_stall  = vld_ff && out_stall;
   assign out_valid = vld_ff;
   assign out_data  = data_ff;

   always_comb begin
      vx      = in_data.vx;
      vy      = in_data.vy;
      dx      = vy >>> STAGE;
      dy      = vx >>> STAGE;
      rot_pos = in_data.side.polar ? !in_data.z[ZW-1] : in_data.vy[DW-1];
      data_in = in_data;
      if (rot_pos) begin
         data_in.vx = vx - dx;
         data_in.vy = vy + dy;
         data_in.z  = in_data.z - ATAN;
      end else begin
         data_in.vx = vx + dx;
         data_in.vy = vy - dy;
         data_in.z  = in_data.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (!in_stall) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/rpc_post.sv -----
// output pipeline: gain correction, sign fold, rounding, saturation
// depends on rpc_pkg; its last stage is the result register
`default_nettype none

module rpc_post #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  rpc_pkg::vec_type   in_data,
   output logic               out_valid,
   input  logic               out_stall,
   output logic signed [31:0] out_x_coord,
   output logic signed [31:0] out_y_coord,
   output logic signed [31:0] out_magnitude,
   output logic signed [31:0] out_angle_rad,
   output logic               out_mode_polar
);
   import rpc_pkg::*;

   localparam int HW = DW - ANG_Q;
   localparam int MW = DW + 2;
   localparam logic signed [63:0]   WORD_MAX = 64'sd2147483647;
   localparam logic signed [63:0]   WORD_MIN = -64'sd2147483648;
   localparam logic signed [DW-1:0] VEC_HALF = DW'(1) <<< (GUARD - 1);
   localparam logic signed [MW-1:0] MAG_HALF = MW'(1) <<< (GUARD - 1);
   localparam logic signed [ZW-1:0] ANG_HALF = ZW'(1) <<< (ANG_Q - FRAC_BITS - 1);

   function automatic logic signed [31:0] sat_word(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > WORD_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < WORD_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   logic [2:0] vld_ff;
   logic [2:0] stall;

   vec_type               q1_data_ff, q1_data_in;
   logic signed [HW+30:0] q1_mhi_ff, q1_mhi_in;
   logic signed [61:0]    q1_mlo_ff, q1_mlo_in;
   vec_type               q2_data_ff;
   logic signed [MW-1:0]  q2_m_ff, q2_m_in;

   logic signed [31:0]    x_ff, x_in;
   logic signed [31:0]    y_ff, y_in;
   logic signed [31:0]    mag_ff, mag_in;
   logic signed [31:0]    ang_ff, ang_in;
   logic                  polar_ff;

   logic signed [HW-1:0]  vx_hi;
   logic signed [30:0]    vx_lo;

   always_comb begin
      stall[2] = vld_ff[2] && out_stall;
      stall[1] = vld_ff[1] && stall[2];
      stall[0] = vld_ff[0] && stall[1];
   end

   assign in_stall       = stall[0];
   assign out_valid      = vld_ff[2];
   assign out_x_coord    = x_ff;
   assign out_y_coord    = y_ff;
   assign out_magnitude  = mag_ff;
   assign out_angle_rad  = ang_ff;
   assign out_mode_polar = polar_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (!stall[0]) vld_ff[0] <= in_valid;
         if (!stall[1]) vld_ff[1] <= vld_ff[0];
         if (!stall[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   // stage 1: split gain product, undo half-turn fold
   always_comb begin
      vx_hi      = $signed(in_data.vx[DW-1:ANG_Q]);
      vx_lo      = $signed({1'b0, in_data.vx[ANG_Q-1:0]});
      q1_mhi_in  = vx_hi * INV_GAIN;
      q1_mlo_in  = vx_lo * INV_GAIN;
      q1_data_in = in_data;
      if (in_data.side.flip) begin
         q1_data_in.vx = -in_data.vx;
         q1_data_in.vy = -in_data.vy;
      end
   end

   // stage 2: gain-corrected length
   assign q2_m_in = MW'(q1_mhi_ff) + MW'(q1_mlo_ff >>> ANG_Q);

   // stage 3: round and saturate the computed values, pass the echoed inputs through
   always_comb begin
      if (q2_data_ff.side.polar) begin
         x_in   = sat_word(64'((q2_data_ff.vx + VEC_HALF) >>> GUARD));
         y_in   = sat_word(64'((q2_data_ff.vy + VEC_HALF) >>> GUARD));
         mag_in = q2_data_ff.side.echo_a;
         ang_in = q2_data_ff.side.echo_b;
      end else begin
         x_in = q2_data_ff.side.echo_a;
         y_in = q2_data_ff.side.echo_b;
         if (q2_data_ff.side.zero) begin
            mag_in = '0;
            ang_in = '0;
         end else begin
            mag_in = sat_word(64'((q2_m_ff + MAG_HALF) >>> GUARD));
            ang_in = sat_word(64'((q2_data_ff.z + ANG_HALF) >>> (ANG_Q - FRAC_BITS)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall[0]) begin
         q1_data_ff <= q1_data_in;
         q1_mhi_ff  <= q1_mhi_in;
         q1_mlo_ff  <= q1_mlo_in;
      end
      if (!stall[1]) begin
         q2_data_ff <= q1_data_ff;
         q2_m_ff    <= q2_m_in;
      end
      if (!stall[2]) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         mag_ff   <= mag_in;
         ang_ff   <= ang_in;
         polar_ff <= q2_data_ff.side.polar;
      end
   end

endmodule

`default_nettype wire
